// ----- hdl/agb_pkg.sv -----
`timescale 1ns / 1ps

package agb_pkg;

   // Defaults for the top-level parameters
   localparam int GRID_DIM_MAX_DEF = 256;
   localparam int MAX_CELLS_DEF    = 64;

   // Fixed field widths
   localparam int COORD_WIDTH      = 32;
   localparam int CELL_SIZE_WIDTH  = 31;
   localparam int DIM_REG_WIDTH    = 9;
   localparam int RECORD_WIDTH     = 16;
   localparam int CELL_INDEX_WIDTH = 24;
   localparam int CSR_INDEX_WIDTH  = 3;
   localparam int CSR_DATA_WIDTH   = 32;

   // Smallest usable cell edge (1.0 in Q23.8)
   localparam logic [CELL_SIZE_WIDTH-1:0] CELL_SIZE_MIN = 31'd256;

   // Register map
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_ORIGIN_X  = 3'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_ORIGIN_Y  = 3'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_ORIGIN_Z  = 3'd2;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_CELL_SIZE = 3'd3;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_CELLS_X   = 3'd4;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_CELLS_Y   = 3'd5;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_CELLS_Z   = 3'd6;

   // Which box bound goes through the divider
   typedef enum logic [2:0] {
      OP_MIN_X = 3'd0,
      OP_MAX_X = 3'd1,
      OP_MIN_Y = 3'd2,
      OP_MAX_Y = 3'd3,
      OP_MIN_Z = 3'd4,
      OP_MAX_Z = 3'd5
   } op_type;

   // Controller to datapath
   typedef struct packed {
      logic   load;
      logic   div_start;
      logic   div_store;
      op_type op;
      logic   check;
      logic   mul1;
      logic   mul2;
      logic   emit;
   } cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic div_done;
      logic empty;
      logic at_last;
   } status_type;

endpackage

// ----- hdl/agb_divider.sv -----
`timescale 1ns / 1ps

// Restoring unsigned divider, one quotient bit per cycle.
module agb_divider (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  start,
   input  logic [agb_pkg::COORD_WIDTH-1:0]       dividend,
   input  logic [agb_pkg::CELL_SIZE_WIDTH-1:0]   divisor,
   output logic                                  done,
   output logic [agb_pkg::COORD_WIDTH-1:0]       quotient
);

   localparam int NW = agb_pkg::COORD_WIDTH;
   localparam int DW = agb_pkg::CELL_SIZE_WIDTH;
   localparam int CNTW = $clog2(NW);

   logic            active_ff, active_in;
   logic            done_ff, done_in;
   logic [CNTW-1:0] cnt_ff, cnt_in;
   logic [NW-1:0]   dq_ff, dq_in;
   logic [DW-1:0]   rem_ff, rem_in;

   logic [DW:0]     rem_shift;
   logic [DW:0]     rem_diff;
   logic            fits;

   // One shift-subtract step
   always_comb begin
      rem_shift = {rem_ff, dq_ff[NW-1]};
      rem_diff  = rem_shift - {1'b0, divisor};
      fits      = (rem_shift >= {1'b0, divisor});

      active_in = active_ff;
      done_in   = 1'b0;
      cnt_in    = cnt_ff;
      dq_in     = dq_ff;
      rem_in    = rem_ff;
      if (start) begin
         active_in = 1'b1;
         cnt_in    = '0;
         dq_in     = dividend;
         rem_in    = '0;
      end else if (active_ff) begin
         dq_in  = {dq_ff[NW-2:0], fits};
         rem_in = fits ? rem_diff[DW-1:0] : rem_shift[DW-1:0];
         cnt_in = cnt_ff + CNTW'(1);
         if (cnt_ff == CNTW'(NW - 1)) begin
            active_in = 1'b0;
            done_in   = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         done_ff   <= 1'b0;
         cnt_ff    <= '0;
      end else begin
         active_ff <= active_in;
         done_ff   <= done_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      dq_ff  <= dq_in;
      rem_ff <= rem_in;
   end

   assign done     = done_ff;
   assign quotient = dq_ff;

endmodule

// ----- hdl/agb_datapath.sv -----
`timescale 1ns / 1ps

module agb_datapath #(
   parameter int GRID_DIM_MAX = agb_pkg::GRID_DIM_MAX_DEF,
   parameter int MAX_CELLS    = agb_pkg::MAX_CELLS_DEF
) (
   input  logic                                      clock,
   input  logic                                      reset,
   // configuration
   input  logic                                      csr_write_enable,
   input  logic [agb_pkg::CSR_INDEX_WIDTH-1:0]       csr_index,
   input  logic [agb_pkg::CSR_DATA_WIDTH-1:0]        csr_write_data,
   // input word payload
   input  logic [agb_pkg::RECORD_WIDTH-1:0]          req_record_index,
   input  logic signed [agb_pkg::COORD_WIDTH-1:0]    req_min_x,
   input  logic signed [agb_pkg::COORD_WIDTH-1:0]    req_min_y,
   input  logic signed [agb_pkg::COORD_WIDTH-1:0]    req_min_z,
   input  logic signed [agb_pkg::COORD_WIDTH-1:0]    req_max_x,
   input  logic signed [agb_pkg::COORD_WIDTH-1:0]    req_max_y,
   input  logic signed [agb_pkg::COORD_WIDTH-1:0]    req_max_z,
   // control
   input  agb_pkg::cmd_type                          cmd,
   output agb_pkg::status_type                       status,
   // result word payload
   output logic [agb_pkg::CELL_INDEX_WIDTH-1:0]      rsp_cell_index,
   output logic [agb_pkg::RECORD_WIDTH-1:0]          rsp_owner_index,
   output logic                                      rsp_last,
   output logic                                      rsp_truncated
);

   localparam int CWID = agb_pkg::COORD_WIDTH;
   localparam int IW   = agb_pkg::CELL_INDEX_WIDTH;
   // largest dimension a 9-bit register can ask for after clamping
   localparam int DIM_LIMIT = (GRID_DIM_MAX < 511) ? GRID_DIM_MAX : 511;
   localparam int CW = (DIM_LIMIT > 1) ? $clog2(DIM_LIMIT) : 1;  // coordinate
   localparam int DW = CW + 1;                                    // dimension
   localparam int KW = $clog2(MAX_CELLS + 1);                     // word count
   localparam int TW = (3 * DW > KW) ? 3 * DW : KW;               // box volume
   localparam int PW = CW + 2 * DW + 2;                           // cell number

   // Configuration registers
   logic signed [CWID-1:0]                     origin_ff [3];
   logic [agb_pkg::CELL_SIZE_WIDTH-1:0]        cell_size_ff;
   logic [agb_pkg::DIM_REG_WIDTH-1:0]          cells_ff [3];

   always_ff @(posedge clock) begin
      if (reset) begin
         origin_ff[0] <= '0;
         origin_ff[1] <= '0;
         origin_ff[2] <= '0;
         cell_size_ff <= agb_pkg::CELL_SIZE_MIN;
         cells_ff[0]  <= 9'd1;
         cells_ff[1]  <= 9'd1;
         cells_ff[2]  <= 9'd1;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            agb_pkg::REG_ORIGIN_X:  origin_ff[0] <= csr_write_data;
            agb_pkg::REG_ORIGIN_Y:  origin_ff[1] <= csr_write_data;
            agb_pkg::REG_ORIGIN_Z:  origin_ff[2] <= csr_write_data;
            agb_pkg::REG_CELL_SIZE: cell_size_ff <= csr_write_data[30:0];
            agb_pkg::REG_CELLS_X:   cells_ff[0]  <= csr_write_data[8:0];
            agb_pkg::REG_CELLS_Y:   cells_ff[1]  <= csr_write_data[8:0];
            agb_pkg::REG_CELLS_Z:   cells_ff[2]  <= csr_write_data[8:0];
            default: ;
         endcase
      end
   end

   // Effective cell size and dimensions
   logic [agb_pkg::CELL_SIZE_WIDTH-1:0] cs_eff;
   logic [DW-1:0]                       dim [3];
   logic [DW-1:0]                       dim_m1 [3];

   assign cs_eff = (cell_size_ff < agb_pkg::CELL_SIZE_MIN) ? agb_pkg::CELL_SIZE_MIN
                                                           : cell_size_ff;

   always_comb begin
      for (int a = 0; a < 3; a++) begin
         if (cells_ff[a] == '0)
            dim[a] = DW'(1);
         else if (cells_ff[a] > 9'(DIM_LIMIT))
            dim[a] = DW'(DIM_LIMIT);
         else
            dim[a] = DW'(cells_ff[a]);
         dim_m1[a] = dim[a] - DW'(1);
      end
   end

   // Box capture
   logic signed [CWID-1:0]              min_ff [3];
   logic signed [CWID-1:0]              max_ff [3];
   logic [agb_pkg::RECORD_WIDTH-1:0]    held_index_ff;

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         min_ff[0]     <= req_min_x;
         min_ff[1]     <= req_min_y;
         min_ff[2]     <= req_min_z;
         max_ff[0]     <= req_max_x;
         max_ff[1]     <= req_max_y;
         max_ff[2]     <= req_max_z;
         held_index_ff <= req_record_index;
      end
   end

   // Divider operand select: bound minus origin, 33 bits signed
   logic [1:0]             axis;
   logic                   is_hi;
   logic signed [CWID-1:0] bound;
   logic signed [CWID-1:0] org;
   logic [DW-1:0]          dim_sel;
   logic [DW-1:0]          dim_m1_sel;
   logic [CWID:0]          diff;
   logic                   neg;

   always_comb begin
      axis       = 2'd0;
      is_hi      = 1'b0;
      bound      = min_ff[0];
      org        = origin_ff[0];
      dim_sel    = dim[0];
      dim_m1_sel = dim_m1[0];
      unique case (cmd.op)
         agb_pkg::OP_MIN_X: begin
            axis = 2'd0; is_hi = 1'b0; bound = min_ff[0];
            org = origin_ff[0]; dim_sel = dim[0]; dim_m1_sel = dim_m1[0];
         end
         agb_pkg::OP_MAX_X: begin
            axis = 2'd0; is_hi = 1'b1; bound = max_ff[0];
            org = origin_ff[0]; dim_sel = dim[0]; dim_m1_sel = dim_m1[0];
         end
         agb_pkg::OP_MIN_Y: begin
            axis = 2'd1; is_hi = 1'b0; bound = min_ff[1];
            org = origin_ff[1]; dim_sel = dim[1]; dim_m1_sel = dim_m1[1];
         end
         agb_pkg::OP_MAX_Y: begin
            axis = 2'd1; is_hi = 1'b1; bound = max_ff[1];
            org = origin_ff[1]; dim_sel = dim[1]; dim_m1_sel = dim_m1[1];
         end
         agb_pkg::OP_MIN_Z: begin
            axis = 2'd2; is_hi = 1'b0; bound = min_ff[2];
            org = origin_ff[2]; dim_sel = dim[2]; dim_m1_sel = dim_m1[2];
         end
         agb_pkg::OP_MAX_Z: begin
            axis = 2'd2; is_hi = 1'b1; bound = max_ff[2];
            org = origin_ff[2]; dim_sel = dim[2]; dim_m1_sel = dim_m1[2];
         end
         default: ;
      endcase
      diff = {bound[CWID-1], bound} - {org[CWID-1], org};
      neg  = diff[CWID];
   end

   // A negative offset floors below zero, so the quotient counts only for a
   // non-negative offset; the low 32 bits of the offset go to the divider.
   logic            div_done;
   logic [CWID-1:0] quotient;

   agb_divider u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend (diff[CWID-1:0]),
      .divisor  (cs_eff),
      .done     (div_done),
      .quotient (quotient)
   );

   logic over;
   assign over = (quotient >= CWID'(dim_sel));

   // Span per axis; empty flag collects every reason for no output
   logic [CW-1:0] span_low_ff [3];
   logic [CW-1:0] span_high_ff [3];
   logic [DW-1:0] width_ff [3];
   logic          empty_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         empty_ff <= 1'b0;
      end else if (cmd.load) begin
         empty_ff <= 1'b0;
      end else if (cmd.div_store) begin
         if (is_hi ? neg : (!neg && over))
            empty_ff <= 1'b1;
      end else if (cmd.check) begin
         if (span_low_ff[0] > span_high_ff[0] || span_low_ff[1] > span_high_ff[1] ||
             span_low_ff[2] > span_high_ff[2])
            empty_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.div_store) begin
         if (is_hi)
            span_high_ff[axis] <= over ? dim_m1_sel[CW-1:0] : quotient[CW-1:0];
         else
            span_low_ff[axis] <= neg ? '0 : quotient[CW-1:0];
      end
      if (cmd.check) begin
         for (int a = 0; a < 3; a++)
            width_ff[a] <= {1'b0, span_high_ff[a]} - {1'b0, span_low_ff[a]} + DW'(1);
      end
   end

   // Volume over the mul1 and mul2 multiply steps, plus the y-z plane size
   logic [2*DW-1:0] plane_ff;
   logic [2*DW-1:0] p1_ff;
   logic [TW-1:0]   volume;
   logic [KW-1:0]   total_ff;
   logic            trunc_ff;

   assign volume = TW'(p1_ff) * TW'(width_ff[2]);

   always_ff @(posedge clock) begin
      if (cmd.check)
         plane_ff <= (2*DW)'(dim[1]) * (2*DW)'(dim[2]);
      if (cmd.mul1)
         p1_ff <= (2*DW)'(width_ff[0]) * (2*DW)'(width_ff[1]);
      if (cmd.mul2) begin
         trunc_ff <= (volume > TW'(MAX_CELLS));
         total_ff <= (volume > TW'(MAX_CELLS)) ? KW'(MAX_CELLS) : volume[KW-1:0];
      end
   end

   // Cell walk: x innermost, then y, then z
   logic [CW-1:0] cursor_ff [3];
   logic [KW-1:0] count_ff;
   logic          at_last;
   logic [PW-1:0] cell_full;

   assign at_last   = ((count_ff + KW'(1)) == total_ff);
   assign cell_full = PW'(cursor_ff[0]) * PW'(plane_ff) +
                      PW'(cursor_ff[1]) * PW'(dim[2]) + PW'(cursor_ff[2]);

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else if (cmd.mul2) begin
         count_ff <= '0;
      end else if (cmd.emit) begin
         count_ff <= count_ff + KW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.mul2) begin
         for (int a = 0; a < 3; a++)
            cursor_ff[a] <= span_low_ff[a];
      end else if (cmd.emit) begin
         if (cursor_ff[0] == span_high_ff[0]) begin
            cursor_ff[0] <= span_low_ff[0];
            if (cursor_ff[1] == span_high_ff[1]) begin
               cursor_ff[1] <= span_low_ff[1];
               cursor_ff[2] <= cursor_ff[2] + CW'(1);
            end else begin
               cursor_ff[1] <= cursor_ff[1] + CW'(1);
            end
         end else begin
            cursor_ff[0] <= cursor_ff[0] + CW'(1);
         end
      end
   end

   // Result word register
   logic [agb_pkg::CELL_INDEX_WIDTH-1:0] rsp_cell_index_ff;
   logic [agb_pkg::RECORD_WIDTH-1:0]     rsp_owner_index_ff;
   logic                                 rsp_last_ff;
   logic                                 rsp_truncated_ff;

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         rsp_cell_index_ff  <= IW'(cell_full);
         rsp_owner_index_ff <= held_index_ff;
         rsp_last_ff        <= at_last;
         rsp_truncated_ff   <= trunc_ff;
      end
   end

   assign rsp_cell_index  = rsp_cell_index_ff;
   assign rsp_owner_index = rsp_owner_index_ff;
   assign rsp_last        = rsp_last_ff;
   assign rsp_truncated   = rsp_truncated_ff;

   assign status.div_done = div_done;
   assign status.empty    = empty_ff;
   assign status.at_last  = at_last;

endmodule

// ----- hdl/agb_ctrl.sv -----
`timescale 1ns / 1ps

module agb_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output agb_pkg::cmd_type      cmd,
   input  agb_pkg::status_type   status
);

   typedef enum logic [6:0] {
      S_IDLE   = 7'b0000001,
      S_DSTART = 7'b0000010,
      S_DWAIT  = 7'b0000100,
      S_CHECK  = 7'b0001000,
      S_MUL1   = 7'b0010000,
      S_MUL2   = 7'b0100000,
      S_EMIT   = 7'b1000000
   } state_type;

   state_type        state_ff, state_in;
   agb_pkg::op_type  op_ff, op_in;
   agb_pkg::op_type  op_next;
   logic             rsp_valid_ff, rsp_valid_in;
   logic             out_free;

   // Division order
   always_comb begin
      unique case (op_ff)
         agb_pkg::OP_MIN_X: op_next = agb_pkg::OP_MAX_X;
         agb_pkg::OP_MAX_X: op_next = agb_pkg::OP_MIN_Y;
         agb_pkg::OP_MIN_Y: op_next = agb_pkg::OP_MAX_Y;
         agb_pkg::OP_MAX_Y: op_next = agb_pkg::OP_MIN_Z;
         agb_pkg::OP_MIN_Z: op_next = agb_pkg::OP_MAX_Z;
         default:           op_next = agb_pkg::OP_MIN_X;
      endcase
   end

   assign out_free = !rsp_valid_ff || !rsp_stall;

   // Next state and commands
   always_comb begin
      state_in      = state_ff;
      op_in         = op_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      cmd.load      = 1'b0;
      cmd.div_start = 1'b0;
      cmd.div_store = 1'b0;
      cmd.op        = op_ff;
      cmd.check     = 1'b0;
      cmd.mul1      = 1'b0;
      cmd.mul2      = 1'b0;
      cmd.emit      = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               op_in    = agb_pkg::OP_MIN_X;
               state_in = S_DSTART;
            end
         end
         S_DSTART: begin
            cmd.div_start = 1'b1;
            state_in      = S_DWAIT;
         end
         S_DWAIT: begin
            if (status.div_done) begin
               cmd.div_store = 1'b1;
               if (op_ff == agb_pkg::OP_MAX_Z) begin
                  state_in = S_CHECK;
               end else begin
                  op_in    = op_next;
                  state_in = S_DSTART;
               end
            end
         end
         S_CHECK: begin
            cmd.check = 1'b1;
            state_in  = S_MUL1;
         end
         S_MUL1: begin
            cmd.mul1 = 1'b1;
            state_in = S_MUL2;
         end
         S_MUL2: begin
            cmd.mul2 = 1'b1;
            state_in = status.empty ? S_IDLE : S_EMIT;
         end
         S_EMIT: begin
            if (out_free) begin
               cmd.emit     = 1'b1;
               rsp_valid_in = 1'b1;
               if (status.at_last)
                  state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         op_ff        <= agb_pkg::OP_MIN_X;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         op_ff        <= op_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

// ----- hdl/aabb_uniform_grid_binner.sv -----
`timescale 1ns / 1ps

// Uniform-grid box binner.
// Input channel (req_*): one box per word, record index plus min and max
// corners in signed Q23.8. Result channel (rsp_*): one word per overlapped
// cell, linear cell number x*ny*nz + y*nz + z, the record index, last on the
// final word of a box and truncated on every word of a box whose run was cut
// at MAX_CELLS. Cells go out with x fastest, then y, then z.
// Configuration (csr_*): origin, cell size and cell counts; the user must
// write them only while idle, which the block itself does not enforce. The
// six bound offsets go one after another through a shared 32-step restoring
// divider; after the span check and the multiply steps the first word is
// registered, then one word per cycle while rsp_stall is low. A box that
// touches no cell gives no word. One box is in work at a time; req_stall is
// high from accept until its last word is loaded into the output register or
// the box is found empty. rsp_stall holds the output register and pauses the
// cell walk; nothing is dropped. Synchronous reset returns the registers to
// origin 0, cell size 1.0, one cell per axis, and empties the output register.
module aabb_uniform_grid_binner #(
   parameter int GRID_DIM_MAX = agb_pkg::GRID_DIM_MAX_DEF,
   parameter int MAX_CELLS    = agb_pkg::MAX_CELLS_DEF
) (
   input  logic                                      clock,
   input  logic                                      reset,
   input  logic                                      csr_write_enable,
   input  logic [agb_pkg::CSR_INDEX_WIDTH-1:0]       csr_index,
   input  logic [agb_pkg::CSR_DATA_WIDTH-1:0]        csr_write_data,
   input  logic                                      req_valid,
   output logic                                      req_stall,
   input  logic [agb_pkg::RECORD_WIDTH-1:0]          req_record_index,
   input  logic signed [agb_pkg::COORD_WIDTH-1:0]    req_min_x,
   input  logic signed [agb_pkg::COORD_WIDTH-1:0]    req_min_y,
   input  logic signed [agb_pkg::COORD_WIDTH-1:0]    req_min_z,
   input  logic signed [agb_pkg::COORD_WIDTH-1:0]    req_max_x,
   input  logic signed [agb_pkg::COORD_WIDTH-1:0]    req_max_y,
   input  logic signed [agb_pkg::COORD_WIDTH-1:0]    req_max_z,
   output logic                                      rsp_valid,
   input  logic                                      rsp_stall,
   output logic [agb_pkg::CELL_INDEX_WIDTH-1:0]      rsp_cell_index,
   output logic [agb_pkg::RECORD_WIDTH-1:0]          rsp_owner_index,
   output logic                                      rsp_last,
   output logic                                      rsp_truncated
);

   agb_pkg::cmd_type    cmd;
   agb_pkg::status_type status;

   agb_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd),
      .status    (status)
   );

   agb_datapath #(
      .GRID_DIM_MAX (GRID_DIM_MAX),
      .MAX_CELLS    (MAX_CELLS)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .req_record_index (req_record_index),
      .req_min_x        (req_min_x),
      .req_min_y        (req_min_y),
      .req_min_z        (req_min_z),
      .req_max_x        (req_max_x),
      .req_max_y        (req_max_y),
      .req_max_z        (req_max_z),
      .cmd              (cmd),
      .status           (status),
      .rsp_cell_index   (rsp_cell_index),
      .rsp_owner_index  (rsp_owner_index),
      .rsp_last         (rsp_last),
      .rsp_truncated    (rsp_truncated)
   );

endmodule

// ----- hdl/agb_checker.sv -----
`timescale 1ns / 1ps

module agb_checker (
   input logic                                      clock,
   input logic                                      reset,
   input logic                                      req_valid,
   input logic                                      req_stall,
   input logic                                      rsp_valid,
   input logic                                      rsp_stall,
   input logic [agb_pkg::CELL_INDEX_WIDTH-1:0]      rsp_cell_index,
   input logic [agb_pkg::RECORD_WIDTH-1:0]          rsp_owner_index,
   input logic                                      rsp_last,
   input logic                                      rsp_truncated
);

   // An accepted box keeps the input side stalled while it is worked on
   assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("input not stalled after accepting a box");

   // A new result word only comes out of a busy block
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_stall))
      else $error("result word appeared while idle");

   // While words of a box are still to come the block takes no new box
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stall && !rsp_last |-> req_stall)
      else $error("input open before the last word of a box");

   // A stalled result word holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_cell_index) &&
         $stable(rsp_owner_index) && $stable(rsp_last) && $stable(rsp_truncated))
      else $error("stalled result word changed");

endmodule

bind aabb_uniform_grid_binner agb_checker u_agb_checker (.*);
